>>> design/assert_macros.svh
// Assertion macros shared by the block table search design.
// Depends on i_clk and i_rst_n being visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/btns_pkg.sv
// Package for the block table nearest-sum search: payload types, codes and
// the command and status structs between controller and datapath. No dependencies.
package btns_pkg;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_FIND   = 2'd2
    } t_command;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_STATE   = 2'd2,
        ST_NOMATCH = 2'd3
    } t_status;

    localparam int MATCH_W = 4;

    typedef struct packed {
        t_command           command;
        logic [7:0]         slot_index;
        logic signed [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        logic [MATCH_W-1:0]   match_index;
    } t_out_item;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_DECODE,
        FSM_SCAN,
        FSM_DRAIN
    } t_fsm_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic exec;
        logic scan_clr;
        logic scan_step;
        logic find_done;
    } t_dp_ctl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;
        logic ptr_last;
        logic pipe_empty;
    } t_dp_sts;

endpackage

>>> design/btns_ctrl.sv
// Controller state machine for the block table nearest-sum search.
// Depends on btns_pkg; drives the datapath through t_dp_ctl.
module btns_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  btns_pkg::t_dp_sts i_sts,
    output btns_pkg::t_dp_ctl o_ctl,
    output logic             o_busy
);
    import btns_pkg::*;

    t_fsm_state r_state;
    t_fsm_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FSM_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_busy  = 1'b1;
        case (r_state)
            FSM_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_ctl.latch = 1'b1;
                    n_state     = FSM_DECODE;
                end
            end
            FSM_DECODE: begin
                if (i_sts.need_scan) begin
                    o_ctl.scan_clr = 1'b1;
                    n_state        = FSM_SCAN;
                end else begin
                    o_ctl.exec = 1'b1;
                    n_state    = FSM_IDLE;
                end
            end
            FSM_SCAN: begin
                o_ctl.scan_step = 1'b1;
                if (i_sts.ptr_last) begin
                    n_state = FSM_DRAIN;
                end
            end
            FSM_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    o_ctl.find_done = 1'b1;
                    n_state         = FSM_IDLE;
                end
            end
            default: begin
                n_state = FSM_IDLE;
            end
        endcase
    end

endmodule

>>> design/btns_dp.sv
// Datapath for the block table nearest-sum search: slot sum memory, flags,
// stream accumulator, scan pipeline and result register. Depends on btns_pkg.
`include "assert_macros.svh"

module btns_dp #(
    parameter int SLOT_COUNT  = 16,
    parameter int BLOCK_BYTES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  btns_pkg::t_in_item i_item,
    input  btns_pkg::t_dp_ctl  i_ctl,
    output btns_pkg::t_dp_sts  o_sts,
    output logic               o_done,
    output btns_pkg::t_out_item o_result
);
    import btns_pkg::*;

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int SUM_W = $clog2(BLOCK_BYTES * 128) + 1;
    localparam int CNT_W = $clog2(BLOCK_BYTES + 1);
    localparam int DIF_W = SUM_W + 1;

    // Latched command.
    t_command           r_cmd;
    logic [IDX_W-1:0]   r_idx;
    logic               r_range_ok;
    logic signed [7:0]  r_byte;

    // Stream and slot state.
    logic signed [SUM_W-1:0] r_pend;
    logic [CNT_W-1:0]        r_fill;
    logic [SLOT_COUNT-1:0]   r_alloc;
    logic signed [SUM_W-1:0] r_mem [SLOT_COUNT];
    logic signed [SUM_W-1:0] r_rd_a;
    logic signed [SUM_W-1:0] r_rd_b;

    // Scan pipeline.
    logic [IDX_W-1:0] r_ptr;
    logic             r_s1_vld;
    logic [IDX_W-1:0] r_s1_idx;
    logic             r_s2_vld;
    logic [IDX_W-1:0] r_s2_idx;
    logic [DIF_W-1:0] r_s2_diff;
    logic             r_found;
    logic [DIF_W-1:0] r_best;
    logic [IDX_W-1:0] r_best_idx;

    logic      r_done;
    t_out_item r_res;

    logic                    alloc_sel;
    logic                    app_go;
    logic                    rem_go;
    t_status                 exec_st;
    logic signed [SUM_W-1:0] pend_add;
    logic [CNT_W-1:0]        fill_inc;
    logic                    fill_last;
    logic                    mem_we;
    logic signed [DIF_W-1:0] diff_s;
    logic [DIF_W-1:0]        diff_u;
    logic                    better;
    logic [IDX_W+MATCH_W-1:0] best_ext;

    assign alloc_sel = r_alloc[r_idx];
    assign pend_add  = r_pend + SUM_W'(r_byte);
    assign fill_inc  = r_fill + CNT_W'(1);
    assign fill_last = (fill_inc == CNT_W'(BLOCK_BYTES));
    assign mem_we    = i_ctl.exec && app_go && fill_last;

    always_comb begin
        exec_st = ST_OK;
        app_go  = 1'b0;
        rem_go  = 1'b0;
        case (r_cmd)
            CMD_APPEND: begin
                if (!r_range_ok) begin
                    exec_st = ST_RANGE;
                end else if (alloc_sel) begin
                    exec_st = ST_STATE;
                end else begin
                    app_go = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (!r_range_ok) begin
                    exec_st = ST_RANGE;
                end else if (!alloc_sel) begin
                    exec_st = ST_STATE;
                end else begin
                    rem_go = 1'b1;
                end
            end
            CMD_FIND: begin
                if (!r_range_ok) begin
                    exec_st = ST_RANGE;
                end else if (!alloc_sel) begin
                    exec_st = ST_STATE;
                end
            end
            default: begin
                exec_st = ST_OK;
            end
        endcase
    end

    assign o_sts.need_scan  = (r_cmd == CMD_FIND) && r_range_ok && alloc_sel;
    assign o_sts.ptr_last   = (r_ptr == IDX_W'(SLOT_COUNT - 1));
    assign o_sts.pipe_empty = !r_s1_vld && !r_s2_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd      <= i_item.command;
            r_idx      <= i_item.slot_index[IDX_W-1:0];
            r_range_ok <= ({1'b0, i_item.slot_index} < 9'(SLOT_COUNT));
            r_byte     <= i_item.data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= '0;
            r_fill  <= '0;
            r_alloc <= '0;
        end else if (i_ctl.exec) begin
            if (app_go) begin
                if (fill_last) begin
                    r_pend         <= '0;
                    r_fill         <= '0;
                    r_alloc[r_idx] <= 1'b1;
                end else begin
                    r_pend <= pend_add;
                    r_fill <= fill_inc;
                end
            end
            if (rem_go) begin
                r_alloc[r_idx] <= 1'b0;
            end
        end
    end

    // Port A follows the addressed slot, port B follows the scan pointer.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_idx] <= pend_add;
        end
        r_rd_a <= r_mem[r_idx];
        r_rd_b <= r_mem[r_ptr];
    end

    assign diff_s = DIF_W'(r_rd_a) - DIF_W'(r_rd_b);
    assign diff_u = diff_s[DIF_W-1] ? DIF_W'(-diff_s) : DIF_W'(diff_s);
    // Strict compare keeps the lower index on a tie, since slots arrive in order.
    assign better = r_s2_vld && (!r_found || (r_s2_diff < r_best));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr    <= '0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            if (i_ctl.scan_clr) begin
                r_ptr   <= '0;
                r_found <= 1'b0;
            end else if (i_ctl.scan_step) begin
                r_ptr <= r_ptr + IDX_W'(1);
            end
            r_s1_vld <= i_ctl.scan_step && r_alloc[r_ptr] && (r_ptr != r_idx);
            r_s2_vld <= r_s1_vld;
            if (better) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx  <= r_ptr;
        r_s2_idx  <= r_s1_idx;
        r_s2_diff <= diff_u;
        if (better) begin
            r_best     <= r_s2_diff;
            r_best_idx <= r_s2_idx;
        end
    end

    assign best_ext = {{MATCH_W{1'b0}}, r_best_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctl.exec || i_ctl.find_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_res.status      <= exec_st;
            r_res.match_index <= '0;
        end else if (i_ctl.find_done) begin
            r_res.status      <= r_found ? ST_OK : ST_NOMATCH;
            r_res.match_index <= r_found ? best_ext[MATCH_W-1:0] : '0;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    `ASSERT_SAME(a_scan_skips_self, r_s2_vld, r_s2_idx != r_idx,
        "scan compared the addressed slot with itself")
    `ASSERT_SAME(a_exec_not_scan, i_ctl.exec, !o_sts.need_scan,
        "a find that needs a scan was executed directly")
    `ASSERT_SAME(a_fill_in_block, 1'b1, r_fill < CNT_W'(BLOCK_BYTES),
        "stream byte count reached the block size")

endmodule

>>> design/block_table_nearest_sum_search.sv
// Top level of the block table nearest-sum search.
// Depends on btns_pkg, btns_ctrl and btns_dp.
//
//   channel   handshake          payload
//   command   start / busy       i_item  (t_in_item)
//   result    o_done strobe      o_result (t_out_item)
//
// Append, remove, a rejected find and the unused code go from the decode state straight to
// the registered result, and the next transfer can come at the edge that takes the result.
// A find on an allocated slot runs a scan that reads one stored sum per cycle from the
// second memory port, then drains a two-stage difference and compare pipeline, which
// empties sooner when the last slots are free.
// Reset clears the slot flags and the stream; the sum memory needs no clearing.
// The result strobe lasts one cycle and cannot be stalled.
`include "assert_macros.svh"

module block_table_nearest_sum_search #(
    parameter int SLOT_COUNT  = 16,
    parameter int BLOCK_BYTES = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  btns_pkg::t_in_item  i_item,
    output logic                busy,
    output logic                o_done,
    output btns_pkg::t_out_item o_result
);
    import btns_pkg::*;

    t_dp_ctl ctl;
    t_dp_sts sts;

    btns_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    btns_dp #(
        .SLOT_COUNT  (SLOT_COUNT),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_ctl    (ctl),
        .o_sts    (sts),
        .o_done   (o_done),
        .o_result (o_result)
    );

    `ASSERT_NEXT(a_accept_busy, start && !busy, busy,
        "block not busy after a command transfer")
    `ASSERT_NEXT(a_done_single, o_done, !o_done,
        "result strobe lasted more than one cycle")
    `ASSERT_SAME(a_match_zero, o_done && (o_result.status != ST_OK),
        o_result.match_index == '0, "match index not zero on a failing status")

endmodule
